// ===== design/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants
// Types, constants and float helpers for the binary64 bounding box block.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int unsigned NUM_AXES = 3;
	localparam int unsigned WIT_W = 20;
	localparam longint unsigned MAX_POINTS = 64'd1048576;
	localparam int unsigned CNT_W = $clog2(MAX_POINTS + 64'd1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
	localparam logic [CNT_W-1:0] IDX_SAT = CNT_W'(MAX_POINTS - 64'd1);

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [62:0] MAX_FINITE_MAG = 63'h7FEF_FFFF_FFFF_FFFF;

	typedef logic [1:0] axis_t;

	typedef struct packed {
		logic [63:0] x_bits;
		logic [63:0] y_bits;
		logic [63:0] z_bits;
		logic last_point;
	} point_t;

	typedef struct packed {
		axis_t axis_index;
		logic [63:0] lower_bound;
		logic [63:0] upper_bound;
		logic [WIT_W-1:0] lower_witness;
		logic [WIT_W-1:0] upper_witness;
		logic [63:0] lower_pad_bits;
		logic [63:0] upper_pad_bits;
		logic lower_unavailable;
		logic upper_unavailable;
		logic last_axis;
	} result_t;

	typedef struct packed {
		logic [63:0] min_bits;
		logic [63:0] max_bits;
		logic [WIT_W-1:0] min_index;
		logic [WIT_W-1:0] max_index;
	} lane_t;

	function automatic logic [63:0] fold_zero(input logic [63:0] b);
		return (b == SIGN_BIT) ? 64'd0 : b;
	endfunction

	function automatic logic [63:0] order_key(input logic [63:0] b);
		return b[63] ? ~b : (b | SIGN_BIT);
	endfunction

endpackage

// ===== design/aabb_if.sv =====
// ----------------------------------------------------------------------------
// aabb_if: valid/ready channel
// Carries one item of a given payload type between source and sink.
// ----------------------------------------------------------------------------
interface aabb_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/aabb_lane.sv =====
// ----------------------------------------------------------------------------
// aabb_lane: per-axis extreme tracker
// Keeps min and max of one coordinate with first-witness indices.
// ----------------------------------------------------------------------------
module aabb_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic first,
	input  logic [aabb_pkg::WIT_W-1:0] idx,
	input  logic [63:0] coord,
	output aabb_pkg::lane_t lane
);
	logic [63:0] b;
	logic [63:0] k;
	logic take_min;
	logic take_max;
	aabb_pkg::lane_t lane_q;

	assign b = aabb_pkg::fold_zero(coord);
	assign k = aabb_pkg::order_key(b);
	assign take_min = first || (k < aabb_pkg::order_key(lane_q.min_bits));
	assign take_max = first || (k > aabb_pkg::order_key(lane_q.max_bits));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
		end else if (en) begin
			if (take_min) begin
				lane_q.min_bits <= b;
				lane_q.min_index <= idx;
			end
			if (take_max) begin
				lane_q.max_bits <= b;
				lane_q.max_index <= idx;
			end
		end
	end

	// combined view of the state after this item, for the last point
	always_comb begin
		lane = lane_q;
		if (take_min) begin
			lane.min_bits = b;
			lane.min_index = idx;
		end
		if (take_max) begin
			lane.max_bits = b;
			lane.max_index = idx;
		end
	end
endmodule

// ===== design/aabb_pad.sv =====
// ----------------------------------------------------------------------------
// aabb_pad: one-ulp outward padding
// Builds a result from one axis's bounds, stepping them out by one ulp.
// ----------------------------------------------------------------------------
module aabb_pad (
	input  aabb_pkg::axis_t axis,
	input  aabb_pkg::lane_t lane,
	output aabb_pkg::result_t res
);
	logic [62:0] mlo;
	logic [62:0] mhi;

	assign mlo = lane.min_bits[62:0];
	assign mhi = lane.max_bits[62:0];

	always_comb begin
		res = '0;
		res.axis_index = axis;
		res.lower_bound = lane.min_bits;
		res.upper_bound = lane.max_bits;
		res.lower_witness = lane.min_index;
		res.upper_witness = lane.max_index;
		res.last_axis = (axis == aabb_pkg::axis_t'(aabb_pkg::NUM_AXES - 1));
		if (!lane.min_bits[63]) begin
			if (mlo == '0) res.lower_pad_bits = aabb_pkg::SIGN_BIT | 64'd1;
			else if (mlo > aabb_pkg::MAX_FINITE_MAG)
				res.lower_pad_bits = {1'b0, aabb_pkg::MAX_FINITE_MAG};
			else res.lower_pad_bits = {1'b0, mlo - 63'd1};
		end else if (mlo >= aabb_pkg::MAX_FINITE_MAG) begin
			res.lower_unavailable = 1'b1;
		end else begin
			res.lower_pad_bits = {1'b1, mlo + 63'd1};
		end
		if (!lane.max_bits[63]) begin
			if (mhi >= aabb_pkg::MAX_FINITE_MAG) res.upper_unavailable = 1'b1;
			else res.upper_pad_bits = {1'b0, mhi + 63'd1};
		end else if (mhi > aabb_pkg::MAX_FINITE_MAG) begin
			res.upper_pad_bits = {1'b1, aabb_pkg::MAX_FINITE_MAG};
		end else if (mhi <= 63'd1) begin
			res.upper_pad_bits = '0;
		end else begin
			res.upper_pad_bits = {1'b1, mhi - 63'd1};
		end
	end
endmodule

// ===== design/binary64_aabb_with_ulp_padding.sv =====
// ----------------------------------------------------------------------------
// binary64_aabb_with_ulp_padding: streaming 3D bounding box
// Tracks per-axis extremes of binary64 points and emits padded bounds.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  pts      in   point_t  (x_bits, y_bits, z_bits, last_point)
//  res      out  result_t (one per axis, three per cloud)
//
// Points are taken one per cycle unless input is held off as below; three lanes compare in parallel.
// A last point loads a three-entry output buffer; its results leave on the
// following cycles, one per cycle in which res.ready is high.
// Input is held off while the buffer drains, except in the cycle its third
// result leaves, so the first point of the next cloud can be taken in that cycle.
// Reset clears extremes, counter and output state.
module binary64_aabb_with_ulp_padding (
	input logic clk,
	input logic arst_n,
	aabb_if.sink pts,
	aabb_if.source res
);
	logic [aabb_pkg::CNT_W-1:0] cnt_q;
	logic [aabb_pkg::CNT_W-1:0] idx_full;
	logic acc;
	logic first;
	aabb_pkg::lane_t lane [aabb_pkg::NUM_AXES];
	aabb_pkg::result_t pad [aabb_pkg::NUM_AXES];
	aabb_pkg::result_t buf_q [aabb_pkg::NUM_AXES];
	logic [1:0] rd_q;
	logic busy_q;
	logic [63:0] coord [aabb_pkg::NUM_AXES];

	assign coord[0] = pts.data.x_bits;
	assign coord[1] = pts.data.y_bits;
	assign coord[2] = pts.data.z_bits;

	assign first = (cnt_q == '0);
	assign idx_full = (cnt_q < aabb_pkg::CNT_MAX) ? cnt_q : aabb_pkg::IDX_SAT;
	assign pts.ready = !busy_q || (res.ready && rd_q == 2'(aabb_pkg::NUM_AXES - 1));
	assign acc = pts.valid && pts.ready;

	for (genvar a = 0; a < aabb_pkg::NUM_AXES; a++) begin : g_lane
		aabb_lane u_lane (
			.clk(clk), .arst_n(arst_n), .en(acc), .first(first),
			.idx(idx_full[aabb_pkg::WIT_W-1:0]), .coord(coord[a]), .lane(lane[a])
		);
		aabb_pad u_pad (.axis(aabb_pkg::axis_t'(a)), .lane(lane[a]), .res(pad[a]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			if (pts.data.last_point) cnt_q <= '0;
			else if (cnt_q < aabb_pkg::CNT_MAX) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_q <= '0;
		end else if (acc && pts.data.last_point) begin
			busy_q <= 1'b1;
			rd_q <= '0;
		end else if (busy_q && res.ready) begin
			if (rd_q == 2'(aabb_pkg::NUM_AXES - 1)) begin
				busy_q <= 1'b0;
				rd_q <= '0;
			end else begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && pts.data.last_point) begin
			for (int a = 0; a < aabb_pkg::NUM_AXES; a++) buf_q[a] <= pad[a];
		end
	end

	assign res.valid = busy_q;
	assign res.data = buf_q[rd_q];
endmodule

// ===== dv/tb_binary64_aabb_with_ulp_padding.sv =====
// ----------------------------------------------------------------------------
// tb_binary64_aabb_with_ulp_padding: bounding box block testbench
// Streams point clouds through the block, predicts per-axis bounds, witnesses
// and one-ulp padding, and compares every result field against the prediction.
// ----------------------------------------------------------------------------
module tb_binary64_aabb_with_ulp_padding;

	localparam logic [63:0] MAG_M = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAXF = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] QNAN = 64'h7FF8_0000_0000_0001;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	aabb_if #(.payload_t(aabb_pkg::point_t)) pts ();
	aabb_if #(.payload_t(aabb_pkg::result_t)) res ();

	binary64_aabb_with_ulp_padding dut (.clk(clk), .arst_n(arst_n), .pts(pts), .res(res));

	logic [63:0] lo_bits [3];
	logic [63:0] hi_bits [3];
	logic [aabb_pkg::WIT_W-1:0] lo_idx [3];
	logic [aabb_pkg::WIT_W-1:0] hi_idx [3];
	longint unsigned cloud_count;
	aabb_pkg::result_t bounds_q [$];
	int errors;
	int idle_cycles;
	bit src_idle_en;
	bit snk_idle_en;
	bit hold_sink;
	int hold_len;
	int snk_gap;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [63:0] to_key(input logic [63:0] b);
		return b[63] ? ~b : {1'b1, b[62:0]};
	endfunction

	function automatic logic [63:0] step_up(input logic [63:0] b, output logic none);
		logic [63:0] m;
		m = b & MAG_M;
		none = 1'b0;
		if (!b[63]) begin
			if (m >= MAXF) begin
				none = 1'b1;
				return 64'd0;
			end
			return m + 64'd1;
		end
		if (m > MAXF)
			return aabb_pkg::SIGN_BIT | MAXF;
		if (m <= 64'd1)
			return 64'd0;
		return aabb_pkg::SIGN_BIT | (m - 64'd1);
	endfunction

	function automatic logic [63:0] step_down(input logic [63:0] b, output logic none);
		logic [63:0] m;
		m = b & MAG_M;
		none = 1'b0;
		if (!b[63]) begin
			if (m == 64'd0)
				return aabb_pkg::SIGN_BIT | 64'd1;
			if (m > MAXF)
				return MAXF;
			return m - 64'd1;
		end
		if (m >= MAXF) begin
			none = 1'b1;
			return 64'd0;
		end
		return aabb_pkg::SIGN_BIT | (m + 64'd1);
	endfunction

	task automatic predict_bounds(input aabb_pkg::point_t p);
		logic [63:0] c [3];
		logic [63:0] b;
		logic [aabb_pkg::WIT_W-1:0] idx;
		bit first;
		aabb_pkg::result_t r;
		logic n;
		c[0] = p.x_bits;
		c[1] = p.y_bits;
		c[2] = p.z_bits;
		first = (cloud_count == 0);
		idx = (cloud_count < aabb_pkg::MAX_POINTS) ? aabb_pkg::WIT_W'(cloud_count)
			: aabb_pkg::WIT_W'(aabb_pkg::MAX_POINTS - 1);
		for (int a = 0; a < 3; a++) begin
			b = (c[a] == aabb_pkg::SIGN_BIT) ? 64'd0 : c[a];
			if (first || to_key(b) < to_key(lo_bits[a])) begin
				lo_bits[a] = b;
				lo_idx[a] = idx;
			end
			if (first || to_key(b) > to_key(hi_bits[a])) begin
				hi_bits[a] = b;
				hi_idx[a] = idx;
			end
		end
		if (cloud_count < aabb_pkg::MAX_POINTS)
			cloud_count++;
		if (p.last_point) begin
			for (int a = 0; a < 3; a++) begin
				r.axis_index = aabb_pkg::axis_t'(a);
				r.lower_bound = lo_bits[a];
				r.upper_bound = hi_bits[a];
				r.lower_witness = lo_idx[a];
				r.upper_witness = hi_idx[a];
				r.lower_pad_bits = step_down(lo_bits[a], n);
				r.lower_unavailable = n;
				r.upper_pad_bits = step_up(hi_bits[a], n);
				r.upper_unavailable = n;
				r.last_axis = (a == 2);
				bounds_q.push_back(r);
			end
			cloud_count = 0;
		end
	endtask

	task automatic send_point(input logic [63:0] x, y, z, input logic last);
		aabb_pkg::point_t p;
		int gap;
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			pts.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p.x_bits = x;
		p.y_bits = y;
		p.z_bits = z;
		p.last_point = last;
		pts.valid <= 1'b1;
		pts.data <= p;
		do @(posedge clk); while (!pts.ready);
		predict_bounds(p);
	endtask

	task automatic go_idle();
		pts.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_bits();
		logic [63:0] v;
		int sel;
		sel = $urandom_range(0, 9);
		v = {$urandom, $urandom};
		case (sel)
			0: v = aabb_pkg::SIGN_BIT;
			1: v = 64'd0;
			2: v = MAXF | (64'($urandom_range(0, 1)) << 63);
			3: v = {v[63], 11'h7FF, v[51:0]};
			4: v = {v[63], 11'd0, 48'd0, v[3:0]};
			5: v = {v[63], 11'h3FF, 48'd0, v[3:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_extremes();
		send_point(64'd0, aabb_pkg::SIGN_BIT, MAXF, 1'b1);
		send_point(aabb_pkg::SIGN_BIT | MAXF, MAXF, 64'd1, 1'b0);
		send_point(MAXF, aabb_pkg::SIGN_BIT | MAXF, aabb_pkg::SIGN_BIT | 64'd1, 1'b0);
		send_point(64'd1, 64'd0, 64'd0, 1'b1);
		send_point(aabb_pkg::SIGN_BIT | 64'd1, aabb_pkg::SIGN_BIT | 64'd1,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_point(64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
	endtask

	task automatic test_nonfinite();
		send_point(POS_INF, aabb_pkg::SIGN_BIT | POS_INF, QNAN, 1'b0);
		send_point(aabb_pkg::SIGN_BIT | POS_INF, POS_INF, aabb_pkg::SIGN_BIT | QNAN, 1'b1);
		send_point(POS_INF, POS_INF, 64'hFFF0_0000_0000_0000, 1'b1);
		send_point(QNAN, aabb_pkg::SIGN_BIT | MAXF, 64'h7FF0_0000_0000_0001, 1'b1);
	endtask

	task automatic test_ties();
		send_point(64'h3FF0_0000_0000_0000, aabb_pkg::SIGN_BIT, 64'd5, 1'b0);
		send_point(64'h3FF0_0000_0000_0000, 64'd0, 64'd5, 1'b0);
		send_point(64'h4000_0000_0000_0000, aabb_pkg::SIGN_BIT, 64'd4, 1'b0);
		send_point(64'h3FF0_0000_0000_0000, 64'd0, 64'd6, 1'b1);
		send_point(64'd7, 64'd7, 64'd7, 1'b1);
	endtask

	task automatic test_random_clouds();
		int n;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		for (int i = 0; i < 60; i += n) begin
			n = $urandom_range(1, 8);
			for (int j = 0; j < n; j++)
				send_point(rand_bits(), rand_bits(), rand_bits(), j == n - 1);
		end
	endtask

	task automatic test_backpressure();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_len = 60;
		hold_sink = 1'b1;
		for (int i = 0; i < 12; i++)
			send_point(rand_bits(), rand_bits(), rand_bits(), 1'b1);
		for (int i = 0; i < 15; i++)
			send_point(rand_bits(), rand_bits(), rand_bits(), (i % 3) == 2);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			snk_gap <= 0;
		end else if (hold_sink) begin
			res.ready <= 1'b0;
			if (hold_len > 0)
				hold_len <= hold_len - 1;
			else
				hold_sink <= 1'b0;
		end else if (snk_gap > 0) begin
			res.ready <= 1'b0;
			snk_gap <= snk_gap - 1;
		end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
			res.ready <= 1'b0;
			snk_gap <= $urandom_range(0, 9);
		end else begin
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			aabb_pkg::result_t got;
			aabb_pkg::result_t exp;
			got = res.data;
			if (bounds_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				exp = bounds_q.pop_front();
				if (got.axis_index !== exp.axis_index ||
					got.lower_bound !== exp.lower_bound ||
					got.upper_bound !== exp.upper_bound ||
					got.lower_witness !== exp.lower_witness ||
					got.upper_witness !== exp.upper_witness ||
					got.lower_pad_bits !== exp.lower_pad_bits ||
					got.upper_pad_bits !== exp.upper_pad_bits ||
					got.lower_unavailable !== exp.lower_unavailable ||
					got.upper_unavailable !== exp.upper_unavailable ||
					got.last_axis !== exp.last_axis) begin
					$display("%0t mismatch expected %h actual %h", $time, exp, got);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pts.valid && pts.ready) || (res.valid && res.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb_binary64_aabb_with_ulp_padding: errors");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		cloud_count = 0;
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_sink = 1'b0;
		hold_len = 0;
		for (int a = 0; a < 3; a++) begin
			lo_bits[a] = '0;
			hi_bits[a] = '0;
			lo_idx[a] = '0;
			hi_idx[a] = '0;
		end
		arst_n = 1'b0;
		pts.valid = 1'b0;
		pts.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_nonfinite();
		test_ties();
		test_random_clouds();
		test_backpressure();
		go_idle();
		snk_idle_en = 1'b0;
		while (bounds_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_binary64_aabb_with_ulp_padding: clean");
		else
			$display("tb_binary64_aabb_with_ulp_padding: errors");
		$finish;
	end

endmodule
